// ===== rtl/crc8fe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 frame encoder package
// Shared types, constants and the CRC-8 byte update for the frame encoder.
// ----------------------------------------------------------------------------
package crc8fe_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;

  localparam logic [ByteW-1:0] CrcPoly       = 8'h07;
  localparam logic [ByteW-1:0] CrcTop        = 8'h80;
  localparam logic [ByteW-1:0] CrcInit       = 8'h00;
  localparam logic [ByteW-1:0] HeaderReset   = 8'hAA;
  localparam logic [ByteW-1:0] TrailerReset  = 8'h55;

  localparam logic [CntW-1:0] CntNone     = 3'd0;
  localparam logic [CntW-1:0] CntData     = 3'd1;
  localparam logic [CntW-1:0] CntDataEnd  = 3'd3;
  localparam logic [CntW-1:0] CntStart    = 3'd3;
  localparam logic [CntW-1:0] CntStartEnd = 3'd5;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } kind_e;

  typedef enum logic {
    REG_HEADER  = 1'b0,
    REG_TRAILER = 1'b1
  } reg_sel_e;

  typedef struct packed {
    logic [MaxResults-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                  count;
    logic                             has_trailer;
  } res_t;

  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      if ((c & CrcTop) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crc8fe_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 frame encoder item builder
// Holds the open-frame state and turns one accepted item into its result bytes.
// ----------------------------------------------------------------------------
module crc8fe_builder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        kind_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0] command_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0] frame_length_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0] data_byte_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0] header_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0] trailer_i,
  output crc8fe_pkg::res_t                 res_o
);

  logic                        frame_open_q, frame_open_d;
  logic [crc8fe_pkg::ByteW-1:0] bytes_left_q, bytes_left_d;
  logic [crc8fe_pkg::ByteW-1:0] crc_q, crc_d;
  logic [crc8fe_pkg::ByteW-1:0] crc_next;
  logic [crc8fe_pkg::ByteW-1:0] left_dec;

  assign crc_next = crc8fe_pkg::crc8_update(crc_q, data_byte_i);
  assign left_dec = bytes_left_q - 8'd1;

  always_comb begin
    res_o             = '0;
    frame_open_d      = frame_open_q;
    bytes_left_d      = bytes_left_q;
    crc_d             = crc_q;
    res_o.count       = crc8fe_pkg::CntNone;
    res_o.has_trailer = 1'b0;
    if (kind_i == crc8fe_pkg::KIND_START) begin
      res_o.bytes[0] = header_i;
      res_o.bytes[1] = command_i;
      res_o.bytes[2] = frame_length_i;
      crc_d          = crc8fe_pkg::CrcInit;
      if (frame_length_i == '0) begin
        res_o.bytes[3]    = crc8fe_pkg::CrcInit;
        res_o.bytes[4]    = trailer_i;
        res_o.count       = crc8fe_pkg::CntStartEnd;
        res_o.has_trailer = 1'b1;
        frame_open_d      = 1'b0;
        bytes_left_d      = '0;
      end else begin
        res_o.count  = crc8fe_pkg::CntStart;
        frame_open_d = 1'b1;
        bytes_left_d = frame_length_i;
      end
    end else if (frame_open_q) begin
      res_o.bytes[0] = data_byte_i;
      bytes_left_d   = left_dec;
      crc_d          = crc_next;
      if (left_dec == '0) begin
        res_o.bytes[1]    = crc_next;
        res_o.bytes[2]    = trailer_i;
        res_o.count       = crc8fe_pkg::CntDataEnd;
        res_o.has_trailer = 1'b1;
        frame_open_d      = 1'b0;
        crc_d             = crc8fe_pkg::CrcInit;
      end else begin
        res_o.count = crc8fe_pkg::CntData;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= '0;
      crc_q        <= crc8fe_pkg::CrcInit;
    end else if (accept_i) begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
      crc_q        <= crc_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crc8_frame_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 frame encoder core
// Builds byte-serial frames: header, command, length, payload, CRC-8, trailer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) takes start items and payload
//   data items. The output channel (out_valid_o/out_ready_i) delivers the
//   frame bytes one by one, with last_o on the final byte of each input item
//   and frame_end_o on the trailer byte. An accepted item is turned into its
//   bytes combinationally and registered; they appear on the output in the
//   cycle after acceptance. The output register sends one byte per cycle
//   while out_ready_i is high, and an item yields 1, 3 or 5 bytes. The next
//   item is accepted in the cycle its predecessor's last byte is taken. Data
//   items that arrive with no open frame produce no bytes. Header and trailer
//   bytes are written through the APB port at byte addresses 0 and 4; the
//   user must write them only while the block is idle, which the block does
//   not enforce. Reset closes any open frame, clears the CRC, empties the
//   output register and loads header 0xAA and trailer 0x55. When the receiver
//   stalls, the current byte holds and the input stops accepting until the
//   last byte of the buffered item is taken.
// ----------------------------------------------------------------------------
module crc8_frame_encoder_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic                             kind_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0]     command_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0]     frame_length_i,
  input  wire logic [crc8fe_pkg::ByteW-1:0]     data_byte_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [crc8fe_pkg::ByteW-1:0]     out_byte_o,
  output      logic                             frame_end_o,
  output      logic                             last_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [crc8fe_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [crc8fe_pkg::ApbDataW-1:0]  pwdata,
  output      logic [crc8fe_pkg::ApbDataW-1:0]  prdata,
  output      logic                             pready
);

  logic [crc8fe_pkg::ByteW-1:0] header_q;
  logic [crc8fe_pkg::ByteW-1:0] trailer_q;
  logic                         reg_wr;
  crc8fe_pkg::reg_sel_e         reg_sel;

  crc8fe_pkg::res_t             res_new;
  logic [crc8fe_pkg::MaxResults-1:0][crc8fe_pkg::ByteW-1:0] bytes_q;
  logic [crc8fe_pkg::CntW-1:0]  cnt_q;
  logic                         trl_q;
  logic [crc8fe_pkg::IdxW-1:0]  idx_q;
  logic                         in_fire;
  logic                         out_fire;
  logic                         at_last;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = crc8fe_pkg::reg_sel_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      crc8fe_pkg::REG_HEADER:  prdata[crc8fe_pkg::ByteW-1:0] = header_q;
      crc8fe_pkg::REG_TRAILER: prdata[crc8fe_pkg::ByteW-1:0] = trailer_q;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= crc8fe_pkg::HeaderReset;
      trailer_q <= crc8fe_pkg::TrailerReset;
    end else if (reg_wr) begin
      if (reg_sel == crc8fe_pkg::REG_HEADER) begin
        header_q <= pwdata[crc8fe_pkg::ByteW-1:0];
      end else begin
        trailer_q <= pwdata[crc8fe_pkg::ByteW-1:0];
      end
    end
  end

  assign out_valid_o = (cnt_q != crc8fe_pkg::CntNone);
  assign at_last     = (idx_q == (cnt_q - 3'd1));
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && at_last);
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_byte_o  = bytes_q[idx_q];
  assign last_o      = out_valid_o && at_last;
  assign frame_end_o = out_valid_o && at_last && trl_q;

  crc8fe_builder u_builder (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_fire),
    .kind_i         (kind_i),
    .command_i      (command_i),
    .frame_length_i (frame_length_i),
    .data_byte_i    (data_byte_i),
    .header_i       (header_q),
    .trailer_i      (trailer_q),
    .res_o          (res_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= crc8fe_pkg::CntNone;
      idx_q <= '0;
    end else if (in_fire) begin
      cnt_q <= res_new.count;
      idx_q <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        cnt_q <= crc8fe_pkg::CntNone;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bytes_q <= res_new.bytes;
      trl_q   <= res_new.has_trailer;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < cnt_q))
    else $error("Output index runs past the buffered byte count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end_o |-> last_o)
    else $error("Trailer byte is not the last byte of its item.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !at_last) |=> (out_valid_o && idx_q == $past(idx_q) + 3'd1))
    else $error("Output sequence skipped or lost a byte.");

endmodule
`default_nettype wire
